// File: sv/tcs_pkg.sv
// Shared types, constants and keyword tables for the token classifier stream.
package tcs_pkg;

	localparam int unsigned LENGTH_SAT_DEFAULT = 255;
	localparam int unsigned KW_COUNT = 5;

	localparam logic [2:0] KW_IF    = 3'd0;
	localparam logic [2:0] KW_ELSE  = 3'd1;
	localparam logic [2:0] KW_FOR   = 3'd2;
	localparam logic [2:0] KW_INT   = 3'd3;
	localparam logic [2:0] KW_BREAK = 3'd4;

	localparam logic [7:0] CHAR_SEMI = 8'h3B;

	typedef struct packed {
		logic       is_keyword;
		logic [2:0] keyword_index;
		logic       is_identifier;
		logic       is_constant;
		logic       is_operator;
		logic       is_end_symbol;
		logic       is_unidentified;
		logic [7:0] token_length;
	} result_t;

	function automatic logic is_space(input logic [7:0] c);
		return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= "a") && (c <= "z");
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return (c == "+") || (c == "-") || (c == "=") || (c == "/") || (c == "*") ||
			(c == "%") || (c == "(") || (c == ")") || (c == "<") || (c == ">");
	endfunction

	function automatic logic [2:0] kw_len(input logic [2:0] k);
		logic [2:0] n;
		unique case (k)
			KW_IF:    n = 3'd2;
			KW_ELSE:  n = 3'd4;
			KW_FOR:   n = 3'd3;
			KW_INT:   n = 3'd3;
			KW_BREAK: n = 3'd5;
			default:  n = 3'd0;
		endcase
		return n;
	endfunction

	// Keyword text, first character in the top byte, padded with zero bytes.
	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
		logic [39:0] word;
		logic [7:0]  ch;
		unique case (k)
			KW_IF:    word = {"if", 24'h0};
			KW_ELSE:  word = {"else", 8'h0};
			KW_FOR:   word = {"for", 16'h0};
			KW_INT:   word = {"int", 16'h0};
			KW_BREAK: word = "break";
			default:  word = 40'h0;
		endcase
		unique case (pos)
			3'd0:    ch = word[39:32];
			3'd1:    ch = word[31:24];
			3'd2:    ch = word[23:16];
			3'd3:    ch = word[15:8];
			3'd4:    ch = word[7:0];
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: sv/token_classifier_stream.sv
// Token classifier stream: byte-serial tokenizer with a registered, skid-buffered result.
//
// Input channel: one text byte per beat on char_code, qualified by in_valid and
// held off by in_stall. A whitespace byte (codes 9 to 13 and 32), or a beat with
// end_of_input set, closes the pending token; any other byte extends it.
// Output channel: one classification record per closed token, qualified by
// out_valid and held off by out_stall.
// Throughput is one input beat per cycle while in_stall is low. Each beat
// updates a small set of per-token flag registers; the closing beat is
// classified by short logic from those registers into the result register,
// or into the skid register while the result register holds a stalled record.
// When the receiver stalls, the pending record holds on the output and a second
// record may land in a one-entry skid register; in_stall rises only while that
// skid register is full. Input beats that close no token keep flowing as long as
// in_stall is low.
// Reset empties both result registers and leaves the tokenizer outside a token.
// Token lengths count up to LENGTH_SATURATION and stay there; the output field
// carries the low eight bits of the count.
module token_classifier_stream #(
	parameter int unsigned LENGTH_SATURATION = tcs_pkg::LENGTH_SAT_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_keyword,
	output logic [2:0] keyword_index,
	output logic       is_identifier,
	output logic       is_constant,
	output logic       is_operator,
	output logic       is_end_symbol,
	output logic       is_unidentified,
	output logic [7:0] token_length
);
	import tcs_pkg::*;

	localparam int unsigned LW = $clog2(LENGTH_SATURATION + 1);
	localparam logic [LW-1:0] LEN_MAX = LW'(LENGTH_SATURATION);
	localparam logic [LW-1:0] LEN_ONE = LW'(1);

	logic          in_token_q;
	logic [LW-1:0] len_q;
	logic [7:0]    held_q;
	logic          digits_q;
	logic          ident_q;
	logic          op_q;
	logic [KW_COUNT-1:0] alive_q;

	result_t  main_q;
	result_t  skid_q;
	logic     main_valid_q;
	logic     skid_valid_q;

	logic     accept;
	logic     closing;
	logic     produce;
	logic     out_fire;
	result_t  rec;

	logic [LW-1:0]       pos;
	logic [KW_COUNT-1:0] alive_next;

	assign accept   = in_valid && !in_stall;
	assign closing  = end_of_input || is_space(char_code);
	assign produce  = accept && closing && in_token_q;
	assign out_fire = main_valid_q && !out_stall;
	assign in_stall = skid_valid_q;

	// Position of the held byte within the token, for folding it into the prefix.
	assign pos = len_q - LEN_ONE;

	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			alive_next[k] = alive_q[k] && (pos < LW'(kw_len(3'(k)))) &&
				(kw_char(3'(k), pos[2:0]) == held_q);
		end
	end

	// Classification of the pending token, as it stands before the closing beat.
	always_comb begin
		logic          strip;
		logic          kw;
		logic [2:0]    kidx;
		logic          digits;
		logic          ident;
		logic          op;
		logic          endsy;
		logic [LW-1:0] lm1;
		strip = (held_q == CHAR_SEMI) && (len_q != LEN_ONE);
		lm1   = len_q - LEN_ONE;
		kw    = 1'b0;
		kidx  = KW_IF;
		if (strip) begin
			digits = digits_q;
			ident  = ident_q;
			op     = op_q;
		end else begin
			digits = digits_q && is_digit(held_q);
			ident  = ident_q && ((len_q == LEN_ONE) ? is_lower(held_q) :
				(is_lower(held_q) || is_digit(held_q)));
			op     = op_q || is_op(held_q);
		end
		for (int k = 0; k < KW_COUNT; k++) begin
			if (strip) begin
				if (alive_q[k] && (LW'(kw_len(3'(k))) + LEN_ONE == len_q)) begin
					kw   = 1'b1;
					kidx = 3'(k);
				end
			end else begin
				if (alive_q[k] && (LW'(kw_len(3'(k))) == len_q) &&
					(kw_char(3'(k), lm1[2:0]) == held_q)) begin
					kw   = 1'b1;
					kidx = 3'(k);
				end
			end
		end
		endsy = strip || ((len_q == LEN_ONE) && (held_q == CHAR_SEMI));
		ident = ident && !kw;

		rec.is_keyword      = kw;
		rec.keyword_index   = kw ? kidx : 3'd0;
		rec.is_identifier   = ident;
		rec.is_constant     = digits;
		rec.is_operator     = op;
		rec.is_end_symbol   = endsy;
		rec.is_unidentified = !kw && !ident && !digits && !op && !endsy;
		rec.token_length    = 8'(len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_token_q <= 1'b0;
			len_q      <= '0;
			held_q     <= '0;
			digits_q   <= 1'b1;
			ident_q    <= 1'b1;
			op_q       <= 1'b0;
			alive_q    <= '1;
		end else if (accept) begin
			if (closing) begin
				in_token_q <= 1'b0;
				len_q      <= '0;
				held_q     <= '0;
				digits_q   <= 1'b1;
				ident_q    <= 1'b1;
				op_q       <= 1'b0;
				alive_q    <= '1;
			end else if (!in_token_q) begin
				in_token_q <= 1'b1;
				len_q      <= LEN_ONE;
				held_q     <= char_code;
				digits_q   <= 1'b1;
				ident_q    <= 1'b1;
				op_q       <= 1'b0;
				alive_q    <= '1;
			end else begin
				digits_q <= digits_q && is_digit(held_q);
				ident_q  <= ident_q && ((len_q == LEN_ONE) ? is_lower(held_q) :
					(is_lower(held_q) || is_digit(held_q)));
				op_q     <= op_q || is_op(held_q);
				alive_q  <= alive_next;
				held_q   <= char_code;
				if (len_q < LEN_MAX) begin
					len_q <= len_q + LEN_ONE;
				end
			end
		end
	end

	// Result register with a one-entry skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!produce) begin
				main_valid_q <= 1'b0;
			end
		end else if (produce) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (produce) begin
				main_q <= rec;
			end
		end else if (produce) begin
			if (main_valid_q) begin
				skid_q <= rec;
			end else begin
				main_q <= rec;
			end
		end
	end

	assign out_valid       = main_valid_q;
	assign is_keyword      = main_q.is_keyword;
	assign keyword_index   = main_q.keyword_index;
	assign is_identifier   = main_q.is_identifier;
	assign is_constant     = main_q.is_constant;
	assign is_operator     = main_q.is_operator;
	assign is_end_symbol   = main_q.is_end_symbol;
	assign is_unidentified = main_q.is_unidentified;
	assign token_length    = main_q.token_length;

endmodule
